@@ rtl/bppc_pkg.sv @@
// Shared types and codes for the button pair press classifier.
`timescale 1ns / 1ps

package bppc_pkg;

    // Status codes reported per button.
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_RELEASED = 2'd1;
    localparam logic [1:0] ST_LONG     = 2'd2;
    localparam logic [1:0] ST_PRESSED  = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_DELAY = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_HOLD   = 8'd1;

    localparam int unsigned SINCE_W = 16;
    localparam int unsigned HOLD_W  = 17;
    localparam int unsigned CFG_W   = 16;

    localparam logic [CFG_W-1:0] CHECK_DELAY_RESET = 16'd20;
    localparam logic [CFG_W-1:0] LONG_HOLD_RESET   = 16'd1000;

    typedef struct packed {
        logic level_a;
        logic level_b;
    } t_in_item;

    typedef struct packed {
        logic       pair_pressed;
        logic [1:0] status_a;
        logic [1:0] status_b;
    } t_out_item;

    // Timing settings handed to each button unit.
    typedef struct packed {
        logic [CFG_W-1:0] check_delay;
        logic [CFG_W-1:0] long_hold;
    } t_btn_cfg;

endpackage

@@ rtl/bppc_button.sv @@
// Sampling and press classification for a single active-low button.
`timescale 1ns / 1ps

module bppc_button (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_level,
    input  bppc_pkg::t_btn_cfg i_cfg,
    input  logic              i_pair,
    output logic [1:0]        o_status
);
    import bppc_pkg::*;

    typedef enum logic [3:0] {
        MODE_HELD     = 4'b0001,
        MODE_RELEASED = 4'b0010,
        MODE_LONG     = 4'b0100,
        MODE_PAIRED   = 4'b1000
    } t_mode;

    logic [SINCE_W-1:0] r_since, n_since;
    logic [HOLD_W-1:0]  r_hold, n_hold;
    logic               r_last, n_last;
    t_mode              r_mode, n_mode;

    logic [SINCE_W-1:0] elapsed;
    logic [HOLD_W-1:0]  hold_inc;

    always_comb begin
        elapsed  = (r_since == '1) ? r_since : r_since + 1'b1;
        hold_inc = (r_hold == '1) ? r_hold : r_hold + 1'b1;
        n_since  = elapsed;
        n_hold   = hold_inc;
        n_last   = r_last;
        n_mode   = r_mode;
        o_status = ST_NONE;
        if (elapsed > i_cfg.check_delay) begin
            n_since = '0;
            if (i_level != r_last) begin
                n_last = i_level;
                if (i_level) begin
                    if (r_mode == MODE_HELD) begin
                        n_mode   = MODE_RELEASED;
                        o_status = ST_RELEASED;
                    end
                end else begin
                    n_mode   = MODE_HELD;
                    n_hold   = '0;
                    o_status = ST_PRESSED;
                end
            end else if (!i_level && r_mode == MODE_HELD) begin
                if (hold_inc > {1'b0, i_cfg.long_hold}) begin
                    n_mode   = MODE_LONG;
                    o_status = ST_LONG;
                end else begin
                    o_status = ST_PRESSED;
                end
            end
        end
    end

    // A joint press of both buttons overrides the mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
            r_hold  <= '0;
            r_last  <= 1'b1;
            r_mode  <= MODE_RELEASED;
        end else if (i_step) begin
            r_since <= n_since;
            r_hold  <= n_hold;
            r_last  <= n_last;
            r_mode  <= i_pair ? MODE_PAIRED : n_mode;
        end
    end

endmodule

@@ rtl/button_pair_press_classifier.sv @@
// Top level of the button pair press classifier with its handshake stages.
`timescale 1ns / 1ps
// Path: a result passes through the input register and then the result register; either
// register holds it while the output side stalls.
// Throughput: one tick item per cycle while the output side does not stall; the per-button
// counter increment and compare lie between the input register and the result register.
// Reset (synchronous, active low) empties both stages, restores check_delay to 20 and
// long_hold to 1000, and puts both buttons in the released state with cleared counters.
module button_pair_press_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  bppc_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output bppc_pkg::t_out_item                  o_out_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bppc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [bppc_pkg::CFG_W-1:0]           i_cfg_data
);
    import bppc_pkg::*;

    // Configuration registers. Writes must arrive only while the block is idle; this is
    // not enforced. The port is always ready and indexes beyond the list are ignored.
    t_btn_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_delay <= CHECK_DELAY_RESET;
            r_cfg.long_hold   <= LONG_HOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CHECK_DELAY: r_cfg.check_delay <= i_cfg_data;
                REG_LONG_HOLD:   r_cfg.long_hold   <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Input register. It holds a tick until the result register can take its outcome;
    // the button state advances at that same edge.
    logic     r_s1_valid;
    t_in_item r_s1_item;
    logic     r_out_valid;
    t_out_item r_out_item;

    logic advance;
    logic in_xfer;

    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= i_in_item;
        end
    end

    // Per-button classification. The pair flag is formed from both statuses and fed
    // back so that each button switches to paired mode in the same tick.
    logic [1:0] status_a;
    logic [1:0] status_b;
    logic       pair;

    assign pair = (status_a == ST_PRESSED) && (status_b == ST_PRESSED);

    bppc_button u_button_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_level  (r_s1_item.level_a),
        .i_cfg    (r_cfg),
        .i_pair   (pair),
        .o_status (status_a)
    );

    bppc_button u_button_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_level  (r_s1_item.level_b),
        .i_cfg    (r_cfg),
        .i_pair   (pair),
        .o_status (status_b)
    );

    // Result register. It is reloaded when the input register holds a tick and it is empty or its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item.pair_pressed <= pair;
            r_out_item.status_a     <= status_a;
            r_out_item.status_b     <= status_b;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/bppc_checker.sv @@
// Port-level checks for the button pair press classifier and their binding.
`timescale 1ns / 1ps

module bppc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input bppc_pkg::t_out_item o_out_item
);
    import bppc_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A pair report always comes with a press on both buttons.
    a_pair_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.pair_pressed) |->
        (o_out_item.status_a == ST_PRESSED && o_out_item.status_b == ST_PRESSED))
        else $error("pair reported without both presses");

    // The input side only stalls when a result is waiting and the output is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind button_pair_press_classifier bppc_checker u_bppc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
